### hw/rtl/gsha_pkg.sv
`default_nettype none

package gsha_pkg;

    localparam int NUM_SLOTS = 32;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int HSLOT_W   = 8;
    localparam int GEN_W     = 24;
    localparam int HANDLE_W  = GEN_W + HSLOT_W;

    localparam logic [1:0] MODE_ACQUIRE = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_RESOLVE = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_SLOT    = 2'd1;
    localparam logic [1:0] ST_STALE      = 2'd2;
    localparam logic [1:0] ST_NOT_ACTIVE = 2'd3;

    typedef struct packed {
        logic [1:0]          mode;
        logic [HANDLE_W-1:0] handle;
    } req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle_out;
        logic [4:0]          slot_index;
        logic                slot_active;
        logic [1:0]          status;
    } rsp_t;

endpackage

`default_nettype wire

### hw/rtl/gsha_ram.sv
`default_nettype none

module gsha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/generational_slot_handle_allocator_unit.sv
// An acquire served from the free stack goes through S_IDLE, S_POP and S_EXEC, doing the
// registered reads of the free stack memory and then of the generation memory one after
// the other; every other operation goes from S_IDLE to S_EXEC. A request is taken only in
// S_IDLE, so one item is in work at a time; S_EXEC waits until the last result is taken.
// Reset clears the counters, the activity flags and the generation valid flags, so every
// generation reads as zero; free stack contents stay undefined until pushed.
`default_nettype none

module generational_slot_handle_allocator_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire gsha_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output gsha_pkg::rsp_t     rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_EXEC
    } state_t;

    state_t                                  state_reg, state_next;
    logic [1:0]                              mode_reg, mode_next;
    logic [gsha_pkg::HANDLE_W-1:0]           handle_reg, handle_next;
    logic [gsha_pkg::SLOT_W-1:0]             idx_reg, idx_next;
    logic                                    fail_reg, fail_next;
    logic                                    pop_reg, pop_next;
    logic [gsha_pkg::CNT_W-1:0]              depth_reg, depth_next;
    logic [gsha_pkg::CNT_W-1:0]              used_reg, used_next;
    logic [gsha_pkg::NUM_SLOTS-1:0]          busy_reg, busy_next;
    logic [gsha_pkg::NUM_SLOTS-1:0]          gen_ok_reg, gen_ok_next;
    logic                                    rsp_valid_reg, rsp_valid_next;
    gsha_pkg::rsp_t                          rsp_reg, rsp_next;

    logic                                    stk_we, stk_re;
    logic [gsha_pkg::SLOT_W-1:0]             stk_waddr, stk_raddr, stk_wdata, stk_rdata;
    logic                                    gen_we, gen_re;
    logic [gsha_pkg::SLOT_W-1:0]             gen_waddr, gen_raddr;
    logic [gsha_pkg::GEN_W-1:0]              gen_wdata, gen_rdata, gen_cur;
    logic [gsha_pkg::HSLOT_W-1:0]            hslot;
    logic                                    accept, fire, handle_ok;

    gsha_ram #(
        .WIDTH(gsha_pkg::SLOT_W),
        .DEPTH(gsha_pkg::NUM_SLOTS)
    ) u_stack (
        .clk  (clk),
        .we   (stk_we),
        .waddr(stk_waddr),
        .wdata(stk_wdata),
        .re   (stk_re),
        .raddr(stk_raddr),
        .rdata(stk_rdata)
    );

    gsha_ram #(
        .WIDTH(gsha_pkg::GEN_W),
        .DEPTH(gsha_pkg::NUM_SLOTS)
    ) u_gen (
        .clk  (clk),
        .we   (gen_we),
        .waddr(gen_waddr),
        .wdata(gen_wdata),
        .re   (gen_re),
        .raddr(gen_raddr),
        .rdata(gen_rdata)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign accept    = req_valid && req_ready;
    assign fire      = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp_ready);
    assign hslot     = handle_reg[gsha_pkg::HSLOT_W-1:0];
    assign gen_cur   = gen_ok_reg[idx_reg] ? gen_rdata : '0;
    assign handle_ok = (hslot != '0)
                    && (hslot <= gsha_pkg::HSLOT_W'(used_reg))
                    && (handle_reg[gsha_pkg::HANDLE_W-1:gsha_pkg::HSLOT_W] == gen_cur);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        handle_next    = handle_reg;
        idx_next       = idx_reg;
        fail_next      = fail_reg;
        pop_next       = pop_reg;
        depth_next     = depth_reg;
        used_next      = used_reg;
        busy_next      = busy_reg;
        gen_ok_next    = gen_ok_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        stk_we         = 1'b0;
        stk_waddr      = depth_reg[gsha_pkg::SLOT_W-1:0];
        stk_wdata      = idx_reg;
        stk_re         = 1'b0;
        stk_raddr      = gsha_pkg::SLOT_W'(depth_reg - 1'b1);
        gen_we         = 1'b0;
        gen_waddr      = idx_reg;
        gen_wdata      = gen_cur + 1'b1;
        gen_re         = 1'b0;
        gen_raddr      = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next   = req.mode;
                    handle_next = req.handle;
                    fail_next   = 1'b0;
                    pop_next    = 1'b0;
                    state_next  = S_EXEC;
                    if (req.mode == gsha_pkg::MODE_ACQUIRE)
                    begin
                        if (depth_reg != '0)
                        begin
                            pop_next   = 1'b1;
                            stk_re     = 1'b1;
                            state_next = S_POP;
                        end
                        else if (used_reg < gsha_pkg::CNT_W'(gsha_pkg::NUM_SLOTS))
                        begin
                            idx_next  = used_reg[gsha_pkg::SLOT_W-1:0];
                            gen_re    = 1'b1;
                            gen_raddr = used_reg[gsha_pkg::SLOT_W-1:0];
                        end
                        else
                        begin
                            fail_next = 1'b1;
                        end
                    end
                    else
                    begin
                        idx_next  = gsha_pkg::SLOT_W'(req.handle[gsha_pkg::HSLOT_W-1:0] - 1'b1);
                        gen_re    = 1'b1;
                        gen_raddr = gsha_pkg::SLOT_W'(req.handle[gsha_pkg::HSLOT_W-1:0] - 1'b1);
                    end
                end
            end

            S_POP:
            begin
                idx_next   = stk_rdata;
                gen_re     = 1'b1;
                gen_raddr  = stk_rdata;
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                if (fire)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{handle_out: '0, slot_index: '0, slot_active: 1'b0,
                                       status: gsha_pkg::ST_STALE};
                    case (mode_reg)
                        gsha_pkg::MODE_ACQUIRE:
                        begin
                            if (fail_reg)
                            begin
                                rsp_next.status = gsha_pkg::ST_NO_SLOT;
                            end
                            else
                            begin
                                busy_next[idx_reg] = 1'b1;
                                if (pop_reg)
                                begin
                                    depth_next = depth_reg - 1'b1;
                                end
                                else
                                begin
                                    used_next = used_reg + 1'b1;
                                end
                                rsp_next.handle_out  = {gen_cur,
                                                        gsha_pkg::HSLOT_W'(idx_reg) + 1'b1};
                                rsp_next.slot_index  = 5'(idx_reg);
                                rsp_next.slot_active = 1'b1;
                                rsp_next.status      = gsha_pkg::ST_OK;
                            end
                        end
                        gsha_pkg::MODE_RESOLVE:
                        begin
                            if (handle_ok)
                            begin
                                rsp_next.handle_out  = handle_reg;
                                rsp_next.slot_index  = 5'(idx_reg);
                                rsp_next.slot_active = busy_reg[idx_reg];
                                rsp_next.status      = gsha_pkg::ST_OK;
                            end
                        end
                        gsha_pkg::MODE_RELEASE:
                        begin
                            if (handle_ok && !busy_reg[idx_reg])
                            begin
                                rsp_next.slot_index = 5'(idx_reg);
                                rsp_next.status     = gsha_pkg::ST_NOT_ACTIVE;
                            end
                            else if (handle_ok)
                            begin
                                busy_next[idx_reg]   = 1'b0;
                                gen_we               = 1'b1;
                                gen_ok_next[idx_reg] = 1'b1;
                                if (depth_reg < gsha_pkg::CNT_W'(gsha_pkg::NUM_SLOTS))
                                begin
                                    stk_we     = 1'b1;
                                    depth_next = depth_reg + 1'b1;
                                end
                                rsp_next.handle_out = handle_reg;
                                rsp_next.slot_index = 5'(idx_reg);
                                rsp_next.status     = gsha_pkg::ST_OK;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = gsha_pkg::ST_STALE;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= gsha_pkg::MODE_ACQUIRE;
            handle_reg    <= '0;
            idx_reg       <= '0;
            fail_reg      <= 1'b0;
            pop_reg       <= 1'b0;
            depth_reg     <= '0;
            used_reg      <= '0;
            busy_reg      <= '0;
            gen_ok_reg    <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            handle_reg    <= handle_next;
            idx_reg       <= idx_next;
            fail_reg      <= fail_next;
            pop_reg       <= pop_next;
            depth_reg     <= depth_next;
            used_reg      <= used_next;
            busy_reg      <= busy_next;
            gen_ok_reg    <= gen_ok_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/gsha_checker.sv
`default_nettype none

module gsha_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_ready,
    input wire gsha_pkg::req_t req,
    input wire logic           rsp_valid,
    input wire logic           rsp_ready,
    input wire gsha_pkg::rsp_t rsp
);

    // A result that is not taken stays on the port unchanged.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second item taken while one is in work");

    // Failed operations with status NO_SLOT or STALE carry no handle, slot or activity.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == gsha_pkg::ST_NO_SLOT || rsp.status == gsha_pkg::ST_STALE)
        |-> rsp.handle_out == '0 && rsp.slot_index == '0 && !rsp.slot_active)
        else $error("failed result carries data");

    // A successful result names the slot that its handle encodes.
    a_ok_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == gsha_pkg::ST_OK
        |-> rsp.handle_out[7:0] == 8'(rsp.slot_index) + 8'd1)
        else $error("handle and slot index disagree");

endmodule

bind generational_slot_handle_allocator_unit gsha_checker u_gsha_checker (.*);

`default_nettype wire

### sim/tb_generational_slot_handle_allocator_unit.sv
`timescale 1ns / 1ps

module tb_generational_slot_handle_allocator_unit;

    import gsha_pkg::*;

    class allocator_shadow;

        logic [SLOT_W-1:0] free_stack [NUM_SLOTS];
        int unsigned       free_depth;
        int unsigned       slots_used;
        logic [GEN_W-1:0]  slot_gen   [NUM_SLOTS];
        bit                slot_busy  [NUM_SLOTS];
        rsp_t              expected_rsp [$];
        int                mismatch_count;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                free_stack[i] = '0;
                slot_gen[i]   = '0;
                slot_busy[i]  = 1'b0;
            end
            free_depth     = 0;
            slots_used     = 0;
            mismatch_count = 0;
        endfunction

        function logic [HANDLE_W-1:0] handle_of(int unsigned idx);
            return {slot_gen[idx], 8'(idx + 1)};
        endfunction

        function void note_request(req_t r);
            rsp_t        o;
            int unsigned s;
            int unsigned idx;
            bit          got;
            o   = '0;
            got = 1'b0;
            idx = 0;
            case (r.mode)
                MODE_ACQUIRE:
                begin
                    if (free_depth > 0)
                    begin
                        free_depth--;
                        idx = free_stack[free_depth];
                        got = 1'b1;
                    end
                    else if (slots_used < NUM_SLOTS)
                    begin
                        idx = slots_used;
                        slots_used++;
                        got = 1'b1;
                    end
                    if (got)
                    begin
                        slot_busy[idx] = 1'b1;
                        o.handle_out   = handle_of(idx);
                        o.slot_index   = 5'(idx);
                        o.slot_active  = 1'b1;
                        o.status       = ST_OK;
                    end
                    else
                    begin
                        o.status = ST_NO_SLOT;
                    end
                end
                MODE_UNUSED:
                begin
                    o.status = ST_STALE;
                end
                default:
                begin
                    s = r.handle[HSLOT_W-1:0];
                    if (s == 0 || s > slots_used || r.handle[HANDLE_W-1:HSLOT_W] != slot_gen[s - 1])
                    begin
                        o.status = ST_STALE;
                    end
                    else
                    begin
                        idx          = s - 1;
                        o.slot_index = 5'(idx);
                        if (r.mode == MODE_RESOLVE)
                        begin
                            o.handle_out  = r.handle;
                            o.slot_active = slot_busy[idx];
                            o.status      = ST_OK;
                        end
                        else if (!slot_busy[idx])
                        begin
                            o.status = ST_NOT_ACTIVE;
                        end
                        else
                        begin
                            slot_busy[idx] = 1'b0;
                            slot_gen[idx]  = slot_gen[idx] + 1'b1;
                            if (free_depth < NUM_SLOTS)
                            begin
                                free_stack[free_depth] = SLOT_W'(idx);
                                free_depth++;
                            end
                            o.handle_out = r.handle;
                            o.status     = ST_OK;
                        end
                    end
                end
            endcase
            expected_rsp.push_back(o);
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_rsp.size() == 0)
            begin
                $error("Response item arrived with none expected: %h", got);
                mismatch_count++;
                return;
            end
            want = expected_rsp.pop_front();
            if (got.handle_out !== want.handle_out)
            begin
                $error("handle_out: expected %h, actual %h", want.handle_out, got.handle_out);
                mismatch_count++;
            end
            if (got.slot_index !== want.slot_index)
            begin
                $error("slot_index: expected %0d, actual %0d", want.slot_index, got.slot_index);
                mismatch_count++;
            end
            if (got.slot_active !== want.slot_active)
            begin
                $error("slot_active: expected %b, actual %b", want.slot_active, got.slot_active);
                mismatch_count++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatch_count++;
            end
        endfunction

    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    allocator_shadow shadow;
    bit              quiet;
    bit              start_long_hold;
    bit              hold_done;
    int              hold_left;
    int              rsp_idle_left;

    generational_slot_handle_allocator_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #500us;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic req_t make_req(logic [1:0] m, logic [HANDLE_W-1:0] h);
        req_t r;
        r.mode   = m;
        r.handle = h;
        return r;
    endfunction

    function automatic req_t random_request(int fill_pct);
        req_t        r;
        int unsigned busy_list [$];
        int unsigned idx;
        int          k;
        int          c;
        r.mode   = MODE_ACQUIRE;
        r.handle = $urandom;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (shadow.slot_busy[i])
                busy_list.push_back(i);
        end
        k = $urandom_range(0, 99);
        if (k < fill_pct)
            return r;
        c = $urandom_range(0, 19);
        if (c < 10)
        begin
            if (busy_list.size() != 0)
            begin
                idx      = busy_list[$urandom_range(0, busy_list.size() - 1)];
                r.mode   = MODE_RELEASE;
                r.handle = shadow.handle_of(idx);
            end
        end
        else if (c < 14)
        begin
            r.mode = ($urandom_range(0, 2) == 0) ? MODE_RELEASE : MODE_RESOLVE;
            if (shadow.slots_used > 0)
            begin
                idx      = $urandom_range(0, shadow.slots_used - 1);
                r.handle = shadow.handle_of(idx);
            end
        end
        else if (c < 16)
        begin
            r.mode = ($urandom_range(0, 1) == 0) ? MODE_RELEASE : MODE_RESOLVE;
            if (shadow.slots_used > 0)
            begin
                idx      = $urandom_range(0, shadow.slots_used - 1);
                r.handle = shadow.handle_of(idx);
                r.handle[HANDLE_W-1:HSLOT_W] ^= GEN_W'(1) << $urandom_range(0, GEN_W - 1);
            end
        end
        else if (c == 16)
        begin
            r.mode = ($urandom_range(0, 1) == 0) ? MODE_RELEASE : MODE_RESOLVE;
            if ($urandom_range(0, 1) == 0)
                r.handle[HSLOT_W-1:0] = '0;
            else
                r.handle[HSLOT_W-1:0] = 8'($urandom_range(shadow.slots_used + 1, 255));
        end
        else if (c < 19)
        begin
            r.mode = 2'($urandom_range(1, 3));
        end
        else
        begin
            r.mode = MODE_UNUSED;
        end
        return r;
    endfunction

    task automatic send_item(req_t r);
        int n;
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        shadow.note_request(r);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 4);
            req_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    initial
    begin
        shadow        = new();
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        quiet         = 1'b0;
        start_long_hold = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(make_req(MODE_ACQUIRE, '1));
        send_item(make_req(MODE_RESOLVE, '0));
        send_item(make_req(MODE_RESOLVE, {24'd0, 8'd1}));
        send_item(make_req(MODE_RESOLVE, {24'd0, 8'd255}));
        send_item(make_req(MODE_RESOLVE, {24'd0, 8'd2}));
        send_item(make_req(MODE_UNUSED, '1));
        send_item(make_req(MODE_RELEASE, {24'd0, 8'd1}));
        send_item(make_req(MODE_RELEASE, {24'd0, 8'd1}));
        send_item(make_req(MODE_RELEASE, {24'd1, 8'd1}));
        send_item(make_req(MODE_RESOLVE, {24'd1, 8'd1}));
        send_item(make_req(MODE_ACQUIRE, '0));
        send_item(make_req(MODE_ACQUIRE, 32'h5555_5555));
        send_item(make_req(MODE_RELEASE, {24'hFF_FFFF, 8'd2}));
        send_item(make_req(MODE_RELEASE, {24'd1, 8'd1}));
        send_item(make_req(MODE_RELEASE, {24'd0, 8'd2}));
        send_item(make_req(MODE_ACQUIRE, 32'hAAAA_AAAA));
        send_item(make_req(MODE_ACQUIRE, '0));
        send_item(make_req(MODE_UNUSED, '0));
        send_item(make_req(MODE_RESOLVE, '1));
        send_item(make_req(MODE_RESOLVE, {24'd2, 8'd1}));

        for (int i = 0; i < 950; i++)
        begin
            if (i == 300)
                start_long_hold = 1'b1;
            if (i == 850)
                quiet = 1'b1;
            send_item(random_request(((i / 120) % 2 == 0) ? 75 : 25));
        end
        req_valid <= 1'b0;

        while (shadow.expected_rsp.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (shadow.mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rsp_ready     = 1'b0;
        hold_done     = 1'b0;
        hold_left     = 0;
        rsp_idle_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (start_long_hold && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = 150;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (quiet)
            begin
                rsp_ready <= 1'b1;
            end
            else if (rsp_idle_left > 0)
            begin
                rsp_idle_left--;
                rsp_ready <= 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                rsp_idle_left = $urandom_range(1, 4) - 1;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
                shadow.check_response(rsp);
        end
    end

endmodule
